### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sfp_pkg.sv
package sfp_pkg;

  localparam int FRAME_BYTES = 15;
  localparam int CRC_SPAN    = 13;
  localparam int FILL_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_BYTES - 1);
  localparam logic [FILL_W-1:0] CRC_LAST  = FILL_W'(CRC_SPAN - 1);

  localparam logic [7:0]  ADDR_RESET = 8'h20;
  localparam logic [7:0]  FUNC_RESET = 8'h03;
  localparam logic [7:0]  LEN_BYTE   = 8'h0A;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION = CFG_IDX_W'(1);

  typedef struct packed {
    logic clear;   // restart at CRC_INIT
    logic step;    // advance one bit
    logic load;    // fold the data byte in before this bit
  } crc_ctl_t;

endpackage

### hdl/sfp_crc.sv
module sfp_crc (
  input  logic            clk,
  input  sfp_pkg::crc_ctl_t ctl,
  input  logic [7:0]      data,
  output logic [15:0]     crc
);
  import sfp_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] mix;

  always_comb begin
    mix     = crc_r ^ (ctl.load ? {8'h00, data} : 16'h0000);
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.step) begin
      crc_nxt = mix[0] ? ((mix >> 1) ^ CRC_POLY) : (mix >> 1);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

### hdl/sensor_frame_parser_crc16.sv
// Latency: a header or payload byte's result word is valid right after its accepting edge.
// The fifteenth byte of a frame runs the bit-serial CRC over the first 13 bytes, then a check
// state, then the statistics states when a period is known or the resync shift state, and the
// output state, which waits for the result side; no byte is taken until its word is emitted.
// Other bytes sustain one per cycle while the result side keeps up.
// Reset clears the state machine, fill, counters, statistics, config and out_valid; not the frame buffer, CRC or words.
module sensor_frame_parser_crc16 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  input  logic [31:0]                    in_time_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_frame_valid,
  output logic signed [15:0]             out_line_offset,
  output logic [15:0]                    out_black_level,
  output logic [15:0]                    out_adc_first,
  output logic [15:0]                    out_adc_second,
  output logic [15:0]                    out_adc_third,
  output logic [31:0]                    out_frame_number,
  output logic [31:0]                    out_header_error_total,
  output logic [31:0]                    out_crc_error_total,
  output logic [31:0]                    out_period_min,
  output logic [31:0]                    out_period_max,
  output logic [31:0]                    out_period_average,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_CHECK, S_SHIFT, S_PER, S_AVG, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [7:0]          addr_r, addr_nxt;
  logic [7:0]          func_r, func_nxt;
  logic [31:0]         time_r, time_nxt;
  logic [31:0]         prev_r, prev_nxt;
  logic [31:0]         min_r, min_nxt;
  logic [31:0]         max_r, max_nxt;
  logic [31:0]         avg_r, avg_nxt;
  logic [31:0]         good_cnt_r, good_cnt_nxt;
  logic [31:0]         herr_r, herr_nxt;
  logic [31:0]         cerr_r, cerr_nxt;
  logic [31:0]         period_r, period_nxt;
  logic [34:0]         acc_r, acc_nxt;
  logic [34:0]         sum;
  logic [FILL_W-1:0]   byte_idx_r, byte_idx_nxt;
  logic [2:0]          bit_idx_r, bit_idx_nxt;
  logic                good_r, good_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_frame_valid_r, out_frame_valid_nxt;
  logic signed [15:0]  out_line_offset_r, out_line_offset_nxt;
  logic [15:0]         out_black_level_r, out_black_level_nxt;
  logic [15:0]         out_adc_first_r, out_adc_first_nxt;
  logic [15:0]         out_adc_second_r, out_adc_second_nxt;
  logic [15:0]         out_adc_third_r, out_adc_third_nxt;
  logic [31:0]         out_frame_number_r, out_frame_number_nxt;
  logic [31:0]         out_herr_r, out_herr_nxt;
  logic [31:0]         out_cerr_r, out_cerr_nxt;
  logic [31:0]         out_min_r, out_min_nxt;
  logic [31:0]         out_max_r, out_max_nxt;
  logic [31:0]         out_avg_r, out_avg_nxt;

  logic [7:0]          store_r [FRAME_BYTES];
  logic                st_we;
  logic [FILL_W-1:0]   st_widx;
  logic                st_shift;

  logic                in_acc;
  logic                out_free;
  logic                emit;
  logic                emit_good;

  crc_ctl_t            crc_ctl;
  logic [7:0]          crc_data;
  logic [15:0]         crc_val;

  sfp_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (crc_data),
    .crc  (crc_val)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign crc_data = store_r[byte_idx_r];
  assign sum      = acc_r + {3'b000, period_r} + 35'd4;

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    addr_nxt     = addr_r;
    func_nxt     = func_r;
    time_nxt     = time_r;
    prev_nxt     = prev_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    avg_nxt      = avg_r;
    good_cnt_nxt = good_cnt_r;
    herr_nxt     = herr_r;
    cerr_nxt     = cerr_r;
    period_nxt   = period_r;
    acc_nxt      = acc_r;
    byte_idx_nxt = byte_idx_r;
    bit_idx_nxt  = bit_idx_r;
    good_nxt     = good_r;
    st_we        = 1'b0;
    st_widx      = fill_r;
    st_shift     = 1'b0;
    crc_ctl      = '0;
    emit         = 1'b0;
    emit_good    = 1'b0;

    if (cfg_valid) begin
      if (cfg_index == REG_ADDRESS) begin
        addr_nxt = cfg_data;
      end else if (cfg_index == REG_FUNCTION) begin
        func_nxt = cfg_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (fill_r == FILL_W'(0)) begin
            if (in_rx_byte == addr_r) begin
              st_we    = 1'b1;
              fill_nxt = FILL_W'(1);
            end else begin
              herr_nxt = herr_r + 32'd1;
            end
            emit = 1'b1;
          end else if ((fill_r == FILL_W'(1) && in_rx_byte != func_r) ||
                       (fill_r == FILL_W'(2) && in_rx_byte != LEN_BYTE)) begin
            // bad header byte: restart, keep it if it is the address
            herr_nxt = herr_r + 32'd1;
            if (in_rx_byte == addr_r) begin
              st_we    = 1'b1;
              st_widx  = FILL_W'(0);
              fill_nxt = FILL_W'(1);
            end else begin
              fill_nxt = FILL_W'(0);
            end
            emit = 1'b1;
          end else begin
            st_we    = 1'b1;
            fill_nxt = fill_r + FILL_W'(1);
            if (fill_r == LAST_FILL) begin
              time_nxt      = in_time_ms;
              crc_ctl.clear = 1'b1;
              byte_idx_nxt  = FILL_W'(0);
              bit_idx_nxt   = 3'd0;
              state_nxt     = S_CRC;
            end else begin
              emit = 1'b1;
            end
          end
        end
      end
      S_CRC: begin
        crc_ctl.step = 1'b1;
        crc_ctl.load = (bit_idx_r == 3'd0);
        bit_idx_nxt  = bit_idx_r + 3'd1;
        if (bit_idx_r == 3'd7) begin
          byte_idx_nxt = byte_idx_r + FILL_W'(1);
          if (byte_idx_r == CRC_LAST) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if ({store_r[14], store_r[13]} != crc_val) begin
          cerr_nxt  = cerr_r + 32'd1;
          good_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          good_cnt_nxt = good_cnt_r + 32'd1;
          good_nxt     = 1'b1;
          fill_nxt     = FILL_W'(0);
          prev_nxt     = time_r;
          if (prev_r != 32'd0) begin
            period_nxt = time_r - prev_r;
            state_nxt  = S_PER;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SHIFT: begin
        // drop the lead byte until the next stored address leads
        if (fill_r <= FILL_W'(1)) begin
          fill_nxt  = FILL_W'(0);
          state_nxt = S_OUT;
        end else begin
          st_shift = 1'b1;
          fill_nxt = fill_r - FILL_W'(1);
          if (store_r[1] == addr_r) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_PER: begin
        if (min_r == 32'd0 || period_r < min_r) begin
          min_nxt = period_r;
        end
        if (period_r > max_r) begin
          max_nxt = period_r;
        end
        if (avg_r == 32'd0) begin
          avg_nxt   = period_r;
          state_nxt = S_OUT;
        end else begin
          acc_nxt   = {avg_r, 3'b000} - {3'b000, avg_r};
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        avg_nxt   = sum[34:3];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_good = good_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt        = out_valid_r && !out_ready;
    out_frame_valid_nxt  = out_frame_valid_r;
    out_line_offset_nxt  = out_line_offset_r;
    out_black_level_nxt  = out_black_level_r;
    out_adc_first_nxt    = out_adc_first_r;
    out_adc_second_nxt   = out_adc_second_r;
    out_adc_third_nxt    = out_adc_third_r;
    out_frame_number_nxt = out_frame_number_r;
    out_herr_nxt         = out_herr_r;
    out_cerr_nxt         = out_cerr_r;
    out_min_nxt          = out_min_r;
    out_max_nxt          = out_max_r;
    out_avg_nxt          = out_avg_r;
    if (emit) begin
      out_valid_nxt        = 1'b1;
      out_frame_valid_nxt  = emit_good;
      out_line_offset_nxt  = emit_good ? $signed({store_r[4], store_r[3]}) : 16'sd0;
      out_black_level_nxt  = emit_good ? {store_r[6], store_r[5]} : 16'h0000;
      out_adc_first_nxt    = emit_good ? {store_r[8], store_r[7]} : 16'h0000;
      out_adc_second_nxt   = emit_good ? {store_r[10], store_r[9]} : 16'h0000;
      out_adc_third_nxt    = emit_good ? {store_r[12], store_r[11]} : 16'h0000;
      out_frame_number_nxt = good_cnt_nxt;
      out_herr_nxt         = herr_nxt;
      out_cerr_nxt         = cerr_nxt;
      out_min_nxt          = min_nxt;
      out_max_nxt          = max_nxt;
      out_avg_nxt          = avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      addr_r      <= ADDR_RESET;
      func_r      <= FUNC_RESET;
      prev_r      <= '0;
      min_r       <= '0;
      max_r       <= '0;
      avg_r       <= '0;
      good_cnt_r  <= '0;
      herr_r      <= '0;
      cerr_r      <= '0;
      good_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      addr_r      <= addr_nxt;
      func_r      <= func_nxt;
      prev_r      <= prev_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      avg_r       <= avg_nxt;
      good_cnt_r  <= good_cnt_nxt;
      herr_r      <= herr_nxt;
      cerr_r      <= cerr_nxt;
      good_r      <= good_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r             <= time_nxt;
    period_r           <= period_nxt;
    acc_r              <= acc_nxt;
    byte_idx_r         <= byte_idx_nxt;
    bit_idx_r          <= bit_idx_nxt;
    out_frame_valid_r  <= out_frame_valid_nxt;
    out_line_offset_r  <= out_line_offset_nxt;
    out_black_level_r  <= out_black_level_nxt;
    out_adc_first_r    <= out_adc_first_nxt;
    out_adc_second_r   <= out_adc_second_nxt;
    out_adc_third_r    <= out_adc_third_nxt;
    out_frame_number_r <= out_frame_number_nxt;
    out_herr_r         <= out_herr_nxt;
    out_cerr_r         <= out_cerr_nxt;
    out_min_r          <= out_min_nxt;
    out_max_r          <= out_max_nxt;
    out_avg_r          <= out_avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_shift) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        store_r[i] <= store_r[i+1];
      end
    end else if (st_we) begin
      store_r[st_widx] <= in_rx_byte;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frame_valid        = out_frame_valid_r;
  assign out_line_offset        = out_line_offset_r;
  assign out_black_level        = out_black_level_r;
  assign out_adc_first          = out_adc_first_r;
  assign out_adc_second         = out_adc_second_r;
  assign out_adc_third          = out_adc_third_r;
  assign out_frame_number       = out_frame_number_r;
  assign out_header_error_total = out_herr_r;
  assign out_crc_error_total    = out_cerr_r;
  assign out_period_min         = out_min_r;
  assign out_period_max         = out_max_r;
  assign out_period_average     = out_avg_r;

endmodule

### hdl/sfp_chk.sv
`include "assert_macros.svh"

module sfp_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_frame_valid,
  input logic signed [15:0]  out_line_offset,
  input logic [15:0]         out_black_level,
  input logic [15:0]         out_adc_third,
  input logic [31:0]         out_frame_number,
  input logic [31:0]         out_period_min,
  input logic [31:0]         out_period_max
);

  logic out_stall;
  logic plain_word;
  logic words_zero;

  assign out_stall  = out_valid && !out_ready;
  assign plain_word = out_valid && !out_frame_valid;
  assign words_zero = out_line_offset == 16'sd0 && out_black_level == 16'h0000 &&
                      out_adc_third == 16'h0000;

  // a stalled word holds
  `SFP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_frame_number), "word changed")

  // input is taken only when the result slot is free or draining
  `SFP_ASSERT_NOW(a_slot_free, in_ready && out_valid, out_ready, "ready while word blocked")

  // a word without a good frame carries zero payload words
  `SFP_ASSERT_NOW(a_zero_words, plain_word, words_zero, "payload set without good frame")

  // the minimum period never exceeds the maximum
  `SFP_ASSERT_NOW(a_min_max, out_valid, out_period_min <= out_period_max, "period min above max")

endmodule

bind sensor_frame_parser_crc16 sfp_chk u_sfp_chk (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import sfp_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 130;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
  } serial_byte_t;

  typedef struct packed {
    logic               frame_valid;
    logic signed [15:0] line_offset;
    logic [15:0]        black_level;
    logic [15:0]        adc_first;
    logic [15:0]        adc_second;
    logic [15:0]        adc_third;
    logic [31:0]        frame_number;
    logic [31:0]        header_error_total;
    logic [31:0]        crc_error_total;
    logic [31:0]        period_min;
    logic [31:0]        period_max;
    logic [31:0]        period_average;
  } sensor_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_rx_byte = 8'h00;
  logic [31:0]            in_time_ms = 32'h0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_frame_valid;
  logic signed [15:0]     out_line_offset;
  logic [15:0]            out_black_level;
  logic [15:0]            out_adc_first;
  logic [15:0]            out_adc_second;
  logic [15:0]            out_adc_third;
  logic [31:0]            out_frame_number;
  logic [31:0]            out_header_error_total;
  logic [31:0]            out_crc_error_total;
  logic [31:0]            out_period_min;
  logic [31:0]            out_period_max;
  logic [31:0]            out_period_average;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_ADDRESS;
  logic [7:0]             cfg_data = 8'h00;

  sensor_frame_parser_crc16 dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser state as the block should hold it
  logic [7:0]   addr_cfg = ADDR_RESET;
  logic [7:0]   func_cfg = FUNC_RESET;
  frame_bytes_t rx_buf = '0;
  int unsigned  rx_fill = 0;
  logic [31:0]  prev_frame_ms = 0;
  logic [31:0]  min_gap_ms = 0;
  logic [31:0]  max_gap_ms = 0;
  logic [31:0]  avg_gap_ms = 0;
  logic [31:0]  good_count = 0;
  logic [31:0]  hdr_err_count = 0;
  logic [31:0]  crc_err_count = 0;

  serial_byte_t   pending_bytes[$];
  sensor_report_t expected_reports[$];
  serial_byte_t   next_byte;
  sensor_report_t want;

  int unsigned items_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned max_byte_gap_ms = 3;
  logic [31:0] clock_ms = 0;

  function automatic logic [15:0] modbus_crc(frame_bytes_t fb);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      crc ^= {8'h00, fb[i]};
      for (int k = 0; k < 8; k++)
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // Advance the parser by one byte and return the report it should emit.
  function automatic sensor_report_t parse_byte(logic [7:0] b, logic [31:0] now);
    sensor_report_t r;
    logic [31:0]    gap;
    logic [63:0]    acc;
    bit             found;
    r = '0;
    found = 1'b0;
    if (rx_fill >= FRAME_BYTES)
      rx_fill = 0;
    if (rx_fill == 0) begin
      if (b == addr_cfg) begin
        rx_buf[0] = b;
        rx_fill = 1;
      end else begin
        hdr_err_count++;
      end
    end else if ((rx_fill == 1 && b != func_cfg) || (rx_fill == 2 && b != LEN_BYTE)) begin
      hdr_err_count++;
      if (b == addr_cfg) begin
        rx_buf[0] = b;
        rx_fill = 1;
      end else begin
        rx_fill = 0;
      end
    end else begin
      rx_buf[rx_fill] = b;
      rx_fill++;
      if (rx_fill == FRAME_BYTES) begin
        if ({rx_buf[14], rx_buf[13]} != modbus_crc(rx_buf)) begin
          crc_err_count++;
          // shift the first stored address byte after the head to the front
          for (int s = 1; s < FRAME_BYTES; s++) begin
            if (!found && rx_buf[s] == addr_cfg) begin
              found = 1'b1;
              for (int j = 0; j < FRAME_BYTES - s; j++)
                rx_buf[j] = rx_buf[j + s];
              rx_fill = FRAME_BYTES - s;
            end
          end
          if (!found)
            rx_fill = 0;
        end else begin
          r.frame_valid = 1'b1;
          r.line_offset = {rx_buf[4], rx_buf[3]};
          r.black_level = {rx_buf[6], rx_buf[5]};
          r.adc_first   = {rx_buf[8], rx_buf[7]};
          r.adc_second  = {rx_buf[10], rx_buf[9]};
          r.adc_third   = {rx_buf[12], rx_buf[11]};
          good_count++;
          if (prev_frame_ms != 0) begin
            gap = now - prev_frame_ms;
            if (min_gap_ms == 0 || gap < min_gap_ms)
              min_gap_ms = gap;
            if (gap > max_gap_ms)
              max_gap_ms = gap;
            if (avg_gap_ms == 0) begin
              avg_gap_ms = gap;
            end else begin
              acc = 64'(avg_gap_ms) * 7 + 64'(gap) + 4;
              avg_gap_ms = acc[34:3];
            end
          end
          prev_frame_ms = now;
          rx_fill = 0;
        end
      end
    end
    r.frame_number       = good_count;
    r.header_error_total = hdr_err_count;
    r.crc_error_total    = crc_err_count;
    r.period_min         = min_gap_ms;
    r.period_max         = max_gap_ms;
    r.period_average     = avg_gap_ms;
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, field, exp_val, got_val);
    end
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(parse_byte(in_rx_byte, in_time_ms));
        bytes_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= next_byte.rx_byte;
          in_time_ms <= next_byte.time_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: report word arrived with none expected", $time);
        end else begin
          want = expected_reports.pop_front();
          check_field("frame_valid", 32'(want.frame_valid), 32'(out_frame_valid));
          check_field("line_offset", 32'(want.line_offset), 32'(out_line_offset));
          check_field("black_level", 32'(want.black_level), 32'(out_black_level));
          check_field("adc_first", 32'(want.adc_first), 32'(out_adc_first));
          check_field("adc_second", 32'(want.adc_second), 32'(out_adc_second));
          check_field("adc_third", 32'(want.adc_third), 32'(out_adc_third));
          check_field("frame_number", want.frame_number, out_frame_number);
          check_field("header_error_total", want.header_error_total,
                      out_header_error_total);
          check_field("crc_error_total", want.crc_error_total, out_crc_error_total);
          check_field("period_min", want.period_min, out_period_min);
          check_field("period_max", want.period_max, out_period_max);
          check_field("period_average", want.period_average, out_period_average);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               expected_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ADDRESS)
      addr_cfg = value;
    else if (idx == REG_FUNCTION)
      func_cfg = value;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (bytes_accepted != items_queued || expected_reports.size() != 0);
  endtask

  task automatic queue_byte(logic [7:0] b);
    pending_bytes.push_back('{rx_byte: b, time_ms: clock_ms});
    items_queued++;
    clock_ms += $urandom_range(max_byte_gap_ms, 1);
  endtask

  task automatic queue_frame(frame_bytes_t fb, int unsigned from_idx);
    for (int i = from_idx; i < FRAME_BYTES; i++)
      queue_byte(fb[i]);
  endtask

  function automatic frame_bytes_t make_frame(logic [7:0] a, logic [7:0] f);
    frame_bytes_t fb;
    fb = '0;
    fb[0] = a;
    fb[1] = f;
    fb[2] = LEN_BYTE;
    for (int i = 3; i < CRC_SPAN; i++) begin
      case ($urandom_range(9))
        0: fb[i] = 8'h00;
        1: fb[i] = 8'hFF;
        default: fb[i] = 8'($urandom());
      endcase
    end
    {fb[14], fb[13]} = modbus_crc(fb);
    return fb;
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned  target;
    int unsigned  kind;
    int unsigned  keep;
    int unsigned  pos;
    frame_bytes_t fb;
    frame_bytes_t inner;
    target = items_queued + count;
    while (items_queued < target) begin
      if ($urandom_range(19) == 0)
        clock_ms = $urandom();
      else
        clock_ms += $urandom_range(500, 1);
      kind = $urandom_range(99);
      fb = make_frame(addr_cfg, func_cfg);
      if (kind < 50) begin
        queue_frame(fb, 0);
      end else if (kind < 65) begin
        // break the CRC, often with a stray address in the payload to resync on
        if ($urandom_range(1) == 1) begin
          pos = $urandom_range(12, 3);
          fb[pos] = addr_cfg;
        end
        pos = $urandom_range(14, 13);
        fb[pos] = fb[pos] ^ 8'(1 << $urandom_range(7));
        queue_frame(fb, 0);
      end else if (kind < 78) begin
        // hide the start of a good frame in the tail of a bad one, then finish it
        inner = make_frame(addr_cfg, func_cfg);
        keep = $urandom_range(12, 1);
        for (int i = 0; i < keep; i++)
          fb[FRAME_BYTES - keep + i] = inner[i];
        queue_frame(fb, 0);
        queue_frame(inner, keep);
      end else if (kind < 90) begin
        queue_byte(addr_cfg);
        if ($urandom_range(1) == 1)
          queue_byte(func_cfg);
        queue_byte(8'($urandom()));
      end else begin
        repeat ($urandom_range(3, 1)) queue_byte(8'($urandom()));
      end
    end
  endtask

  initial begin
    frame_bytes_t fb;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 3; p++) begin
      wait_idle();
      case (p)
        0: begin
          sender_idle_pct   = 20;
          receiver_idle_pct = 61;
          write_reg(REG_ADDRESS, 8'h20);
          write_reg(REG_FUNCTION, 8'h03);
        end
        1: begin
          sender_idle_pct   = 61;
          receiver_idle_pct = 20;
          write_reg(REG_SPARE_LO, 8'($urandom()));
          write_reg(REG_ADDRESS, 8'hFF);
          write_reg(REG_FUNCTION, 8'h00);
          write_reg(REG_SPARE_HI, 8'($urandom()));
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          write_reg(REG_ADDRESS, 8'h00);
          write_reg(REG_FUNCTION, 8'hFF);
          // let frame times wrap past zero
          clock_ms = 32'hFFFF_FF00;
        end
      endcase

      if (p == 0) begin
        // one ms per byte so the directed frame ends exactly at time zero
        max_byte_gap_ms = 1;
        clock_ms = 32'hFFFF_FFEB;
        queue_byte(8'h00);
        queue_byte(addr_cfg);
        queue_byte(8'hFF);
        queue_byte(addr_cfg);
        queue_byte(addr_cfg);
        queue_byte(func_cfg);
        queue_byte(8'h0B);
        fb = make_frame(addr_cfg, func_cfg);
        fb[12:3] = 80'hAA55_7FFF_0000_FFFF_8000;
        {fb[14], fb[13]} = modbus_crc(fb);
        queue_frame(fb, 0);
        max_byte_gap_ms = 3;
      end

      for (int c = 0; c < 3; c++) begin
        if (c == 1)
          holds_requested++;
        queue_random(100);
        wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d bytes parsed under three address/function settings, with random stalls",
             bytes_accepted);
    $display("%0d good frames, %0d header errors, %0d crc errors, %0d mismatches",
             good_count, hdr_err_count, crc_err_count, error_count);
    if (error_count == 0 && expected_reports.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
